// ----- src/running_sample_statistics_macros.svh -----
// ----------------------------------------------------------------------------
// running sample statistics assertion macros
// property wrappers shared by the checker of the statistics block
// ----------------------------------------------------------------------------
`ifndef RUNNING_SAMPLE_STATISTICS_MACROS_SVH
`define RUNNING_SAMPLE_STATISTICS_MACROS_SVH

// same-cycle implication
`define RSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rss_pkg.sv -----
// ----------------------------------------------------------------------------
// rss_pkg
// shared constants and types of the running sample statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

  // fraction bits of mean and deviation
  localparam int FRAC_BITS   = 8;

  // result field widths
  localparam int COUNT_OUT_W = 16;
  localparam int TOTAL_W     = 31;
  localparam int MEAN_W      = 23;
  localparam int EXTREME_W   = 15;
  localparam int SD_W        = 23;

  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctrl_t;

endpackage

`default_nettype wire

// ----- src/rss_if.sv -----
// ----------------------------------------------------------------------------
// rss channel interfaces
// valid/ready channels for samples and for run results
// ----------------------------------------------------------------------------
`default_nettype none

interface rss_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rss_out_if;
  import rss_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [COUNT_OUT_W-1:0] sample_count;
  logic [TOTAL_W-1:0]     total;
  logic [MEAN_W-1:0]      mean_value;
  logic [EXTREME_W-1:0]   largest;
  logic [EXTREME_W-1:0]   smallest;
  logic [SD_W-1:0]        std_dev;
  logic                   dropped_flag;

  modport source (
    output valid, output sample_count, output total, output mean_value,
    output largest, output smallest, output std_dev, output dropped_flag,
    input ready
  );
  modport sink (
    input valid, input sample_count, input total, input mean_value,
    input largest, input smallest, input std_dev, input dropped_flag,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/running_sample_statistics.sv -----
// ----------------------------------------------------------------------------
// running_sample_statistics
// count, sum, mean, max, min and population deviation of sample runs
// ----------------------------------------------------------------------------
//  channel  dir  request carries
//  in_i     in   sample (negative value closes the run)
//  out_o    out  sample_count, total, mean_value, largest, smallest,
//                std_dev, dropped_flag
//
//  a non-negative sample never drops ready; outside a close, one per cycle.
//  a negative sample starts the closing sequence on the shared adder:
//    mean divide, n*sum_sq, sum^2, subtract, n^2, variance divide, root;
//    an empty run skips to the load; ready is low until the result is loaded.
//  the result register frees the input side; a new close waits only if the
//    previous result has not been taken yet.
//  reset clears the accumulators (minimum to all ones) and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module running_sample_statistics #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rss_in_if.sink    in_i,
  rss_out_if.source out_o
);
  import rss_pkg::*;

  localparam int MAG = SAMPLE_BITS - 1;
  localparam int SW  = MAG + COUNT_BITS;
  localparam int QSW = 2 * MAG + COUNT_BITS;

  acc_ctrl_t             acc_ctrl;
  logic                  accept;
  logic                  negative;
  logic                  start;
  logic                  idle;
  logic                  clear;
  logic [COUNT_BITS-1:0] count;
  logic [SW-1:0]         sum;
  logic [QSW-1:0]        sumsq;
  logic [MAG-1:0]        run_max;
  logic [MAG-1:0]        run_min;
  logic                  dropped;

  assign accept         = in_i.valid && in_i.ready;
  assign negative       = in_i.sample[SAMPLE_BITS-1];
  assign start          = accept && negative;
  assign acc_ctrl.add   = accept && !negative;
  assign acc_ctrl.clear = clear;
  assign in_i.ready     = idle;

  rss_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (acc_ctrl),
    .mag_i     (in_i.sample[SAMPLE_BITS-2:0]),
    .count_o   (count),
    .sum_o     (sum),
    .sumsq_o   (sumsq),
    .max_o     (run_max),
    .min_o     (run_min),
    .dropped_o (dropped)
  );

  rss_seq #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .count_i   (count),
    .sum_i     (sum),
    .sumsq_i   (sumsq),
    .max_i     (run_max),
    .min_i     (run_min),
    .dropped_i (dropped),
    .idle_o    (idle),
    .clear_o   (clear),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// ----- src/rss_alu.sv -----
// ----------------------------------------------------------------------------
// rss_alu
// shared add/subtract unit with carry out, used by every closing step
// ----------------------------------------------------------------------------
`default_nettype none

module rss_alu #(
  parameter int WIDTH = 63
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] y_o,
  output logic             carry_o
);

  logic [WIDTH:0] sum;
  logic [WIDTH-1:0] b_eff;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign sum   = {1'b0, a_i} + {1'b0, b_eff} + {{WIDTH{1'b0}}, sub_i};

  assign y_o     = sum[WIDTH-1:0];
  // on subtract, carry set means a >= b
  assign carry_o = sum[WIDTH];

endmodule

`default_nettype wire

// ----- src/rss_accum.sv -----
// ----------------------------------------------------------------------------
// rss_accum
// run accumulators: count, sum, sum of squares, max, min, dropped flag
// ----------------------------------------------------------------------------
`default_nettype none

module rss_accum #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  rss_pkg::acc_ctrl_t                      ctrl_i,
  input  logic [SAMPLE_BITS-2:0]                  mag_i,
  output logic [COUNT_BITS-1:0]                   count_o,
  output logic [SAMPLE_BITS+COUNT_BITS-2:0]       sum_o,
  output logic [2*(SAMPLE_BITS-1)+COUNT_BITS-1:0] sumsq_o,
  output logic [SAMPLE_BITS-2:0]                  max_o,
  output logic [SAMPLE_BITS-2:0]                  min_o,
  output logic                                    dropped_o
);
  import rss_pkg::*;

  localparam int MAG  = SAMPLE_BITS - 1;
  localparam int SW   = MAG + COUNT_BITS;
  localparam int QSW  = 2 * MAG + COUNT_BITS;
  localparam int SQW  = 2 * MAG;

  logic [COUNT_BITS-1:0] count_q;
  logic [SW-1:0]         sum_q;
  logic [QSW-1:0]        sumsq_q;
  logic [MAG-1:0]        max_q;
  logic [MAG-1:0]        min_q;
  logic                  dropped_q;
  logic [SQW-1:0]        sq;
  logic                  full;

  assign sq   = SQW'(mag_i) * SQW'(mag_i);
  assign full = (count_q == {COUNT_BITS{1'b1}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sum_q     <= '0;
      sumsq_q   <= '0;
      max_q     <= '0;
      min_q     <= '1;
      dropped_q <= 1'b0;
    end else begin
      priority if (ctrl_i.clear) begin
        count_q   <= '0;
        sum_q     <= '0;
        sumsq_q   <= '0;
        max_q     <= '0;
        min_q     <= '1;
        dropped_q <= 1'b0;
      end else if (ctrl_i.add) begin
        if (full) begin
          dropped_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
          sum_q   <= sum_q + SW'(mag_i);
          sumsq_q <= sumsq_q + QSW'(sq);
          if (mag_i > max_q) begin
            max_q <= mag_i;
          end
          if (mag_i < min_q) begin
            min_q <= mag_i;
          end
        end
      end
    end
  end

  assign count_o   = count_q;
  assign sum_o     = sum_q;
  assign sumsq_o   = sumsq_q;
  assign max_o     = max_q;
  assign min_o     = min_q;
  assign dropped_o = dropped_q;

endmodule

`default_nettype wire

// ----- src/rss_seq.sv -----
// ----------------------------------------------------------------------------
// rss_seq
// closing sequencer: mean, variance and square root on one shared adder
// ----------------------------------------------------------------------------
`default_nettype none

module rss_seq #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [COUNT_BITS-1:0]                   count_i,
  input  logic [SAMPLE_BITS+COUNT_BITS-2:0]       sum_i,
  input  logic [2*(SAMPLE_BITS-1)+COUNT_BITS-1:0] sumsq_i,
  input  logic [SAMPLE_BITS-2:0]                  max_i,
  input  logic [SAMPLE_BITS-2:0]                  min_i,
  input  logic                                    dropped_i,
  output logic                                    idle_o,
  output logic                                    clear_o,
  rss_out_if.source                               out_o
);
  import rss_pkg::*;

  localparam int MAG = SAMPLE_BITS - 1;
  localparam int SW  = MAG + COUNT_BITS;
  localparam int DW  = 2 * SW;                 // n*sum_sq and sum^2
  localparam int XW  = DW + 2 * FRAC_BITS;     // variance dividend
  localparam int QW  = 2 * MAG + 2 * FRAC_BITS; // scaled variance
  localparam int RW  = MAG + FRAC_BITS;        // root and mean
  localparam int UW  = DW + 1;
  localparam int CW  = $clog2(XW + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVM,
    S_P1,
    S_P2,
    S_SUB,
    S_N2,
    S_DIVQ,
    S_SQRT,
    S_LOAD
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_q;
  logic [UW-1:0]   a_q;
  logic [UW-1:0]   b_q;
  logic [XW-1:0]   x_q;
  logic [DW-1:0]   p_q;
  logic [RW-1:0]   root_q;
  logic [RW-1:0]   mean_q;

  logic                   ov_q;
  logic [COUNT_OUT_W-1:0] oc_q;
  logic [TOTAL_W-1:0]     ot_q;
  logic [MEAN_W-1:0]      om_q;
  logic [EXTREME_W-1:0]   omax_q;
  logic [EXTREME_W-1:0]   omin_q;
  logic [SD_W-1:0]        osd_q;
  logic                   odrop_q;

  logic [UW-1:0] alu_a;
  logic [UW-1:0] alu_b;
  logic          alu_sub;
  logic [UW-1:0] alu_y;
  logic          alu_c;
  logic [UW-1:0] a_step;
  logic [XW-1:0] x_div;
  logic [RW-1:0] root_next;
  logic          last;
  logic          can_load;

  rss_alu #(.WIDTH(UW)) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .y_o     (alu_y),
    .carry_o (alu_c)
  );

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_P1, S_P2, S_N2: begin
        // shift-add multiply, multiplier bits from the top of x
        alu_a = {a_q[UW-2:0], 1'b0};
        alu_b = x_q[XW-1] ? b_q : '0;
      end
      S_SUB: begin
        alu_a   = UW'(p_q);
        alu_b   = a_q;
        alu_sub = 1'b1;
      end
      S_DIVM, S_DIVQ: begin
        // restoring divide, one quotient bit per cycle
        alu_a   = {a_q[UW-2:0], x_q[XW-1]};
        alu_b   = b_q;
        alu_sub = 1'b1;
      end
      S_SQRT: begin
        // digit-by-digit root, trial value 4*root + 1
        alu_a   = {a_q[UW-3:0], x_q[XW-1:XW-2]};
        alu_b   = UW'({root_q, 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign a_step    = alu_c ? alu_y : alu_a;
  assign x_div     = {x_q[XW-2:0], alu_c};
  assign root_next = {root_q[RW-2:0], alu_c};
  assign last      = (cnt_q == CW'(1));
  assign can_load  = !ov_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      x_q     <= '0;
      p_q     <= '0;
      root_q  <= '0;
      mean_q  <= '0;
      ov_q    <= 1'b0;
      oc_q    <= '0;
      ot_q    <= '0;
      om_q    <= '0;
      omax_q  <= '0;
      omin_q  <= '0;
      osd_q   <= '0;
      odrop_q <= 1'b0;
    end else begin
      priority if ((state_q == S_LOAD) && can_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (count_i == '0) begin
              mean_q  <= '0;
              root_q  <= '0;
              state_q <= S_LOAD;
            end else begin
              a_q     <= '0;
              b_q     <= UW'(count_i);
              x_q     <= XW'({sum_i, {FRAC_BITS{1'b0}}}) << (XW - SW - FRAC_BITS);
              cnt_q   <= CW'(SW + FRAC_BITS);
              state_q <= S_DIVM;
            end
          end
        end
        S_DIVM: begin
          if (last) begin
            mean_q  <= x_div[RW-1:0];
            a_q     <= '0;
            b_q     <= UW'(sumsq_i);
            x_q     <= XW'(count_i) << (XW - COUNT_BITS);
            cnt_q   <= CW'(COUNT_BITS);
            state_q <= S_P1;
          end else begin
            a_q   <= a_step;
            x_q   <= x_div;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_P1: begin
          if (last) begin
            p_q     <= alu_y[DW-1:0];
            a_q     <= '0;
            b_q     <= UW'(sum_i);
            x_q     <= XW'(sum_i) << (XW - SW);
            cnt_q   <= CW'(SW);
            state_q <= S_P2;
          end else begin
            a_q   <= alu_y;
            x_q   <= x_q << 1;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_P2: begin
          a_q   <= alu_y;
          x_q   <= x_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (last) begin
            state_q <= S_SUB;
          end
        end
        S_SUB: begin
          // n*sum_sq - sum^2
          p_q     <= alu_y[DW-1:0];
          a_q     <= '0;
          b_q     <= UW'(count_i);
          x_q     <= XW'(count_i) << (XW - COUNT_BITS);
          cnt_q   <= CW'(COUNT_BITS);
          state_q <= S_N2;
        end
        S_N2: begin
          if (last) begin
            b_q     <= alu_y;
            a_q     <= '0;
            x_q     <= {p_q, {(2 * FRAC_BITS){1'b0}}};
            cnt_q   <= CW'(XW);
            state_q <= S_DIVQ;
          end else begin
            a_q   <= alu_y;
            x_q   <= x_q << 1;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_DIVQ: begin
          if (last) begin
            a_q     <= '0;
            root_q  <= '0;
            x_q     <= XW'(x_div[QW-1:0]) << (XW - QW);
            cnt_q   <= CW'(QW / 2);
            state_q <= S_SQRT;
          end else begin
            a_q   <= a_step;
            x_q   <= x_div;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_SQRT: begin
          a_q    <= a_step;
          x_q    <= x_q << 2;
          root_q <= root_next;
          cnt_q  <= cnt_q - 1'b1;
          if (last) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (can_load) begin
            oc_q    <= COUNT_OUT_W'(count_i);
            ot_q    <= TOTAL_W'(sum_i);
            om_q    <= MEAN_W'(mean_q);
            omax_q  <= EXTREME_W'(max_i);
            omin_q  <= EXTREME_W'(min_i);
            osd_q   <= SD_W'(root_q);
            odrop_q <= dropped_i;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign idle_o  = (state_q == S_IDLE);
  assign clear_o = (state_q == S_LOAD) && can_load;

  assign out_o.valid        = ov_q;
  assign out_o.sample_count = oc_q;
  assign out_o.total        = ot_q;
  assign out_o.mean_value   = om_q;
  assign out_o.largest      = omax_q;
  assign out_o.smallest     = omin_q;
  assign out_o.std_dev      = osd_q;
  assign out_o.dropped_flag = odrop_q;

endmodule

`default_nettype wire

// ----- src/rss_checker.sv -----
// ----------------------------------------------------------------------------
// rss_checker
// port-level checks of the running sample statistics block
// ----------------------------------------------------------------------------
`default_nettype none

`include "running_sample_statistics_macros.svh"

module rss_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic [SAMPLE_BITS-1:0]         in_sample_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [rss_pkg::COUNT_OUT_W-1:0] out_count_i,
  input logic [rss_pkg::TOTAL_W-1:0]     out_total_i,
  input logic [rss_pkg::MEAN_W-1:0]      out_mean_i,
  input logic [rss_pkg::EXTREME_W-1:0]   out_largest_i,
  input logic [rss_pkg::EXTREME_W-1:0]   out_smallest_i,
  input logic [rss_pkg::SD_W-1:0]        out_sd_i,
  input logic                           out_dropped_i
);
  import rss_pkg::*;

  localparam int PW = COUNT_OUT_W + TOTAL_W + MEAN_W + 2 * EXTREME_W + SD_W + 1;

  logic [PW-1:0] payload;
  logic          in_close;
  logic          in_data;

  assign payload  = {out_count_i, out_total_i, out_mean_i, out_largest_i,
                     out_smallest_i, out_sd_i, out_dropped_i};
  assign in_close = in_valid_i && in_ready_i && in_sample_i[SAMPLE_BITS-1];
  assign in_data  = in_valid_i && in_ready_i && !in_sample_i[SAMPLE_BITS-1];

  // closing request blocks the input while the result is worked out
  `RSS_ASSERT_NXT(a_close_busy, clk_i, rst_ni, in_close, !in_ready_i, "ready after close")

  // data samples never stall the input
  `RSS_ASSERT_NXT(a_data_ready, clk_i, rst_ni, in_data, in_ready_i, "stall after data")

  // non-empty run keeps min at or below max
  `RSS_ASSERT_IMP(a_min_max, clk_i, rst_ni, out_valid_i && (out_count_i != '0), out_smallest_i <= out_largest_i, "min above max")

  // held result keeps its payload
  `RSS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(payload), "result changed while held")

endmodule

bind running_sample_statistics rss_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_rss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_sample_i    (in_i.sample),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_count_i    (out_o.sample_count),
  .out_total_i    (out_o.total),
  .out_mean_i     (out_o.mean_value),
  .out_largest_i  (out_o.largest),
  .out_smallest_i (out_o.smallest),
  .out_sd_i       (out_o.std_dev),
  .out_dropped_i  (out_o.dropped_flag)
);

`default_nettype wire
